// ===== src/imu_rvc_frame_receiver_assert.svh =====
// Assertion macros shared by the receiver RTL.
`ifndef IMU_RVC_FRAME_RECEIVER_ASSERT_SVH
`define IMU_RVC_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IMURVC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("imurvc: implication check failed");

// Next-cycle implication, checked outside reset.
`define IMURVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("imurvc: next-cycle check failed");

`endif

// ===== src/imurvc_pkg.sv =====
`default_nettype none

package imurvc_pkg;

    localparam int BODY_DATA_LEN = 16;
    localparam int POS_W         = 5;

    localparam logic [15:0] HEADER_RESET  = 16'hAAAA;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    // register indexes (paddr[2])
    localparam logic REG_HEADER  = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result event codes
    localparam logic [2:0] EVT_NONE       = 3'd0;
    localparam logic [2:0] EVT_HDR_MATCH  = 3'd1;
    localparam logic [2:0] EVT_HDR_ERROR  = 3'd2;
    localparam logic [2:0] EVT_FRAME_GOOD = 3'd3;
    localparam logic [2:0] EVT_SUM_ERROR  = 3'd4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]         event_res;
        logic               connected;
        logic [7:0]         frame_index;
        logic signed [15:0] yaw_cdeg;
        logic signed [15:0] pitch_cdeg;
        logic signed [15:0] roll_cdeg;
        logic signed [15:0] accel_x_mg;
        logic signed [15:0] accel_y_mg;
        logic signed [15:0] accel_z_mg;
        logic [7:0]         motion_intent;
        logic [7:0]         motion_request;
    } t_res;

    typedef struct packed {
        logic [15:0] header_value;
        logic [15:0] timeout_ticks;
    } t_cfg;

    function automatic logic [15:0] neg_sat16(input logic [15:0] v);
        logic [15:0] r;
        if (v == 16'h8000) begin
            r = 16'h7FFF;
        end else begin
            r = 16'h0000 - v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/imurvc_stream_if.sv =====
`default_nettype none

interface imurvc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/imu_rvc_frame_receiver.sv =====
// Channel     | Dir | Beat contents
// i_req       | in  | req_type, rx_byte (UART byte or 1 ms tick)
// o_res       | out | event_res, connected, frame fields
// APB         | in  | header_value @0x0, timeout_ticks @0x4
//
// One beat per cycle in, one result beat per input beat out.
// The result is registered and valid the cycle after the input beat is taken.
// The result register frees as it is read, so a full register that is
// being taken still lets a new input beat in; only a held result stalls.
// Reset (sync, active low) starts hunting for the header, not connected.
`default_nettype none

`include "imu_rvc_frame_receiver_assert.svh"

module imu_rvc_frame_receiver
    import imurvc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    imurvc_stream_if.sink    i_req,
    imurvc_stream_if.source  o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg cfg;
    t_res res_next;
    t_res r_res;
    logic r_valid;
    logic in_accept;
    logic res_not_good;
    logic res_fields_zero;

    imurvc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_req.ready = !r_valid || o_res.ready;
    assign in_accept   = i_req.valid && i_req.ready;

    imurvc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_req    (i_req.payload),
        .i_cfg    (cfg),
        .o_res    (res_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= res_next;
        end
    end

    assign o_res.valid   = r_valid;
    assign o_res.payload = r_res;

    assign res_not_good    = r_valid && (r_res.event_res != EVT_FRAME_GOOD);
    assign res_fields_zero = (r_res.frame_index == 8'h00) && (r_res.yaw_cdeg == 16'sh0000)
                             && (r_res.motion_request == 8'h00);

    `IMURVC_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, in_accept, r_valid)
    `IMURVC_ASSERT_IMPLY(a_yaw_saturated, i_clk, i_rst_n, r_valid, r_res.yaw_cdeg != 16'sh8000)
    `IMURVC_ASSERT_IMPLY(a_fields_zero_unless_good, i_clk, i_rst_n, res_not_good, res_fields_zero)

endmodule

`default_nettype wire

// ===== src/imurvc_cfg_regs.sv =====
`default_nettype none

module imurvc_cfg_regs
    import imurvc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [15:0] r_header;
    logic [15:0] r_timeout;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_HEADER:  r_header  <= pwdata[15:0];
                REG_TIMEOUT: r_timeout <= pwdata[15:0];
                default:     r_header  <= r_header;
            endcase
        end
    end

    // low address bits are ignored: word-addressed registers
    always_comb begin
        unique case (paddr[2])
            REG_HEADER:  prdata = {16'h0000, r_header};
            REG_TIMEOUT: prdata = {16'h0000, r_timeout};
            default:     prdata = 32'h0000_0000;
        endcase
    end

    assign o_cfg.header_value  = r_header;
    assign o_cfg.timeout_ticks = r_timeout;

endmodule

`default_nettype wire

// ===== src/imurvc_parser.sv =====
`default_nettype none

module imurvc_parser
    import imurvc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_in  i_req,
    input  wire t_cfg i_cfg,
    output t_res      o_res
);

    logic             r_hunting, n_hunting;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_first, n_first;
    logic [7:0]       r_sum, n_sum;
    logic [15:0]      r_ticks, n_ticks;
    logic             r_ever, n_ever;
    logic [7:0]       r_body [BODY_DATA_LEN];

    logic             body_wr;
    logic             good;
    logic [2:0]       evt;

    always_comb begin
        n_hunting = r_hunting;
        n_pos     = r_pos;
        n_first   = r_first;
        n_sum     = r_sum;
        n_ticks   = r_ticks;
        n_ever    = r_ever;
        body_wr   = 1'b0;
        good      = 1'b0;
        evt       = EVT_NONE;
        priority if (i_req.req_type == REQ_TICK) begin
            if (r_ticks != TICK_MAX) begin
                n_ticks = r_ticks + 16'd1;
            end
        end else if (r_hunting) begin
            if (r_pos == '0) begin
                n_first = i_req.rx_byte;
                n_pos   = POS_W'(1);
            end else begin
                n_pos = '0;
                if ({i_req.rx_byte, r_first} == i_cfg.header_value) begin
                    n_hunting = 1'b0;
                    n_sum     = '0;
                    evt       = EVT_HDR_MATCH;
                end else begin
                    evt = EVT_HDR_ERROR;
                end
            end
        end else if (r_pos < POS_W'(BODY_DATA_LEN)) begin
            body_wr = 1'b1;
            n_sum   = r_sum + i_req.rx_byte;
            n_pos   = r_pos + POS_W'(1);
        end else begin
            if (i_req.rx_byte == r_sum) begin
                good    = 1'b1;
                evt     = EVT_FRAME_GOOD;
                n_ticks = '0;
                n_ever  = 1'b1;
            end else begin
                evt = EVT_SUM_ERROR;
            end
            n_hunting = 1'b1;
            n_pos     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting <= 1'b1;
            r_pos     <= '0;
            r_first   <= '0;
            r_sum     <= '0;
            r_ticks   <= '0;
            r_ever    <= 1'b0;
        end else if (i_accept) begin
            r_hunting <= n_hunting;
            r_pos     <= n_pos;
            r_first   <= n_first;
            r_sum     <= n_sum;
            r_ticks   <= n_ticks;
            r_ever    <= n_ever;
        end
    end

    // body bytes are always written before the checksum beat reads them
    always_ff @(posedge i_clk) begin
        if (i_accept && body_wr) begin
            r_body[r_pos[3:0]] <= i_req.rx_byte;
        end
    end

    always_comb begin
        o_res           = '0;
        o_res.event_res = evt;
        o_res.connected = n_ever && (n_ticks < i_cfg.timeout_ticks);
        if (good) begin
            o_res.frame_index    = r_body[0];
            o_res.yaw_cdeg       = neg_sat16({r_body[2], r_body[1]});
            o_res.pitch_cdeg     = {r_body[4], r_body[3]};
            o_res.roll_cdeg      = {r_body[6], r_body[5]};
            o_res.accel_x_mg     = {r_body[8], r_body[7]};
            o_res.accel_y_mg     = {r_body[10], r_body[9]};
            o_res.accel_z_mg     = {r_body[12], r_body[11]};
            o_res.motion_intent  = r_body[13];
            o_res.motion_request = r_body[14];
        end
    end

endmodule

`default_nettype wire
